// ===== hw/rtl/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types, codes and sizes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] FN_APPEND  = 2'd0;
    localparam logic [1:0] FN_DEL_VAL = 2'd1;
    localparam logic [1:0] FN_DEL_POS = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
        logic [5:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [6:0]         length;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic       load;        // capture the request
        logic       append;      // write at tail, count up
        logic       set_status;  // fail or refuse with status code
        logic [1:0] status;
        logic       scan_start;  // idx = 0, read slot 0
        logic       grab_start;  // idx = position, read that slot
        logic       rd_next;     // read slot idx+1
        logic       scan_adv;    // idx = idx+1
        logic       take;        // removed = read data, status done
        logic       shift;       // slot idx = read data, read idx+2, idx++
        logic       dec;         // count down
        logic       out_load;    // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       full;
        logic       pos_ok;
        logic       hit;
        logic       last1;       // idx+1 >= count
        logic       last2;       // idx+2 >= count
    } t_sts;

endpackage

// ===== hw/rtl/ole_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_datapath
// Entry memory, count, scan index and result registers of the list engine.
// ----------------------------------------------------------------------------
module ole_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ole_pkg::t_req i_req,
    input  ole_pkg::t_cmd i_cmd,
    output ole_pkg::t_sts o_sts,
    output ole_pkg::t_rsp o_rsp
);
    import ole_pkg::*;

    logic [31:0]       r_mem [CAPACITY];
    logic [31:0]       r_rd_data;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_idx;
    t_req              r_req;
    logic [1:0]        r_status;
    logic [31:0]       r_removed;
    t_rsp              r_rsp;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(r_idx + ADDR_W'(1));
        if (i_cmd.scan_start) begin
            rd_addr = '0;
        end else if (i_cmd.grab_start) begin
            rd_addr = ADDR_W'(r_req.position);
        end else if (i_cmd.shift) begin
            rd_addr = ADDR_W'(r_idx + ADDR_W'(2));
        end else if (!i_cmd.rd_next) begin
            rd_en = 1'b0;
        end
    end

    always_comb begin
        wr_en   = i_cmd.append || i_cmd.shift;
        wr_addr = i_cmd.append ? ADDR_W'(r_count) : r_idx;
        wr_data = i_cmd.append ? r_req.value : r_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.grab_start) begin
            r_idx <= ADDR_W'(r_req.position);
        end else if (i_cmd.scan_adv || i_cmd.shift) begin
            r_idx <= ADDR_W'(r_idx + ADDR_W'(1));
        end
        if (i_cmd.append) begin
            r_status  <= ST_DONE;
            r_removed <= '0;
        end else if (i_cmd.set_status) begin
            r_status  <= i_cmd.status;
            r_removed <= '0;
        end else if (i_cmd.take) begin
            r_status  <= ST_DONE;
            r_removed <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_rsp.status        <= r_status;
            r_rsp.removed_value <= r_removed;
            r_rsp.length        <= 7'(r_count);
        end
    end

    always_comb begin
        o_sts.func   = r_req.func;
        o_sts.empty  = (r_count == '0);
        o_sts.full   = (r_count >= CNT_W'(CAPACITY));
        o_sts.pos_ok = (32'(r_req.position) < 32'(r_count));
        o_sts.hit    = (r_rd_data == r_req.value);
        o_sts.last1  = ((32'(r_idx) + 32'd1) >= 32'(r_count));
        o_sts.last2  = ((32'(r_idx) + 32'd2) >= 32'(r_count));
    end

    assign o_rsp = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> !o_sts.last1)
        else $error("shift past the last entry");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        ((r_count == $past(r_count) + CNT_W'(1)) ||
         (r_count == $past(r_count) - CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_append_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !o_sts.full)
        else $error("append into a full list");

endmodule

// ===== hw/rtl/ole_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer of the list engine: decode, scan or grab, close-up and reply.
// ----------------------------------------------------------------------------
module ole_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    input  ole_pkg::t_sts i_sts,
    output ole_pkg::t_cmd o_cmd
);
    import ole_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_GRAB   = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_REPLY  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_REPLY;
                case (i_sts.func)
                    FN_APPEND: begin
                        if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    FN_DEL_VAL: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    FN_DEL_POS: begin
                        if (i_sts.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (i_sts.pos_ok) begin
                            o_cmd.grab_start = 1'b1;
                            n_state          = S_GRAB;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_MISS;
                        end
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_MISS;
                    end
                endcase
            end
            S_SCAN: begin
                // compare slot idx while slot idx+1 is being read
                o_cmd.rd_next = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.last1) begin
                        o_cmd.dec = 1'b1;
                        n_state   = S_REPLY;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_sts.last1) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_MISS;
                    n_state          = S_REPLY;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_GRAB: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.take    = 1'b1;
                if (i_sts.last1) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_REPLY;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.last2) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_REPLY;
                end
            end
            S_REPLY: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    a_accept_decides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_DECIDE))
        else $error("accepted item not decoded next cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !i_rsp_ready) |-> !o_cmd.out_load)
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of 32-bit values: append, delete by value, delete at
// position, with close-up of later entries.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  request  | i_req_valid / o_req_ready  | i_req : func, value, position
//  result   | o_rsp_valid / i_rsp_ready  | o_rsp : status, removed_value, length
//
//  Flow: an append or any refused request goes from decode straight to the
//  reply state. A delete by value scans, then closes up one entry per cycle
//  on the entry memory, with its separate read and write ports.
//  A delete at position skips the scan and reads its entry directly.
//  Reset clears the count and control only; a waiting result stalls the next
//  item in its reply state, so the request channel takes one item at a time.
// ----------------------------------------------------------------------------
module ordered_list_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  ole_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output ole_pkg::t_rsp o_rsp
);
    import ole_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ole_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ole_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== tb/ordered_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine. Requests are driven
// through the valid/ready channel with random gaps, and a local list model
// predicts status, removed value and length for every accepted item. The
// checker compares each accepted result with the oldest prediction. Covers
// empty, full, duplicate, miss and out-of-range cases, an unused opcode,
// long result back-pressure and random append/delete traffic.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
    import ole_pkg::*;

    // opcode with no operation behind it; the block must leave the list alone
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam int RSP_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    // local copy of the list
    logic [31:0] list_model [0:CAPACITY-1];
    int          list_len = 0;

    t_rsp pending_results [$];
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    bit   idle_off        = 1'b0;
    bit   hold_rsp_pending = 1'b0;

    ordered_list_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // list model
    // ------------------------------------------------------------------
    function automatic logic [31:0] list_remove(int k);
        logic [31:0] v;
        v = list_model[k];
        for (int j = k; j + 1 < list_len; j++) begin
            list_model[j] = list_model[j + 1];
        end
        list_len--;
        return v;
    endfunction

    function automatic t_rsp list_apply(t_req r);
        t_rsp rsp;
        int   hit;
        rsp.status        = ST_MISS;
        rsp.removed_value = '0;
        hit               = -1;
        case (r.func)
            FN_APPEND: begin
                if (list_len >= CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_model[list_len] = r.value;
                    list_len++;
                    rsp.status = ST_DONE;
                end
            end
            FN_DEL_VAL: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    for (int k = 0; k < list_len && hit < 0; k++) begin
                        if (list_model[k] == r.value) hit = k;
                    end
                end
            end
            FN_DEL_POS: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (int'(r.position) < list_len) begin
                    hit = int'(r.position);
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            rsp.removed_value = list_remove(hit);
            rsp.status        = ST_DONE;
        end
        rsp.length = 7'(list_len);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_req mk_req(logic [1:0] func, logic [31:0] value,
                                    logic [5:0] position);
        t_req r;
        r.func     = func;
        r.value    = value;
        r.position = position;
        return r;
    endfunction

    // mix of wide random, small (for duplicates), extremes and held values
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return $urandom;
        if (roll < 7) return $urandom_range(0, 7);
        if (roll == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        if (list_len > 0) return list_model[$urandom_range(0, list_len - 1)];
        return $urandom;
    endfunction

    function automatic t_req random_req(int append_pct);
        t_req r;
        int   roll;
        r.func     = FN_UNUSED;
        r.value    = $urandom;
        r.position = 6'($urandom_range(0, 63));
        roll       = $urandom_range(0, 99);
        if (roll < 4) begin
            r.func = FN_UNUSED;
        end else if (roll < 4 + append_pct) begin
            r.func  = FN_APPEND;
            r.value = pick_value();
        end else if (roll[0]) begin
            r.func = FN_DEL_VAL;
            if (list_len > 0 && $urandom_range(0, 4) != 0)
                r.value = list_model[$urandom_range(0, list_len - 1)];
            else
                r.value = pick_value();
        end else begin
            r.func = FN_DEL_POS;
            if (list_len > 0 && $urandom_range(0, 4) != 0)
                r.position = 6'($urandom_range(0, list_len - 1));
        end
        return r;
    endfunction

    // present one item after a random gap, predict it when accepted
    task automatic send_item(t_req r);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        pending_results.push_back(list_apply(r));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_list();
        send_item(mk_req(FN_DEL_VAL, 32'h0, 6'd0));
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd0));
        send_item(mk_req(FN_UNUSED, 32'hffff_ffff, 6'd63));
    endtask

    task automatic test_edge_values();
        send_item(mk_req(FN_APPEND, 32'h8000_0000, 6'd0));
        send_item(mk_req(FN_APPEND, 32'h7fff_ffff, 6'd63));
        send_item(mk_req(FN_APPEND, 32'h0000_0000, 6'd0));
        send_item(mk_req(FN_APPEND, 32'hffff_ffff, 6'd0));
        send_item(mk_req(FN_APPEND, 32'd5, 6'd0));
        send_item(mk_req(FN_APPEND, 32'd5, 6'd0));
        send_item(mk_req(FN_DEL_VAL, 32'd12345, 6'd0));       // no match
        send_item(mk_req(FN_DEL_VAL, 32'hffff_ffff, 6'd0));
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd63));          // out of range
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd4));           // last entry
        send_item(mk_req(FN_DEL_VAL, 32'd5, 6'd0));           // only one 5 left
        send_item(mk_req(FN_UNUSED, 32'hffff_ffff, 6'd63));
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd0));
        send_item(mk_req(FN_DEL_VAL, 32'h7fff_ffff, 6'd0));
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd0));           // back to empty
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd0));
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY) send_item(mk_req(FN_APPEND, pick_value(), 6'd0));
        send_item(mk_req(FN_APPEND, 32'h1234_5678, 6'd0));    // refused
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'(CAPACITY - 1)));
        send_item(mk_req(FN_APPEND, 32'h8000_0000, 6'd0));
        send_item(mk_req(FN_DEL_POS, 32'h0, 6'd0));           // close up everything
        send_item(mk_req(FN_APPEND, 32'h7fff_ffff, 6'd0));
        send_item(mk_req(FN_DEL_VAL, list_model[list_len - 1], 6'd0));
    endtask

    // results held off while requests keep coming
    task automatic test_backpressure();
        hold_rsp_pending = 1'b1;
        repeat (16) send_item(random_req(50));
    endtask

    task automatic test_random_traffic();
        int append_pct [10] = '{80, 15, 80, 80, 10, 10, 60, 40, 80, 15};
        for (int ph = 0; ph < 10; ph++) begin
            idle_off = (ph == 3 || ph == 7);
            repeat (80) send_item(random_req(append_pct[ph]));
        end
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random ready with an optional long hold-off
    // ------------------------------------------------------------------
    initial begin : rsp_drive
        int stall;
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp_pending) begin
                hold_rsp_pending = 1'b0;
                i_rsp_ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                stall = idle_off ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    i_rsp_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
            i_rsp_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no pending item: status %0d removed %0d length %0d",
                       o_rsp.status, o_rsp.removed_value, o_rsp.length);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_rsp.status);
                    mismatch_count++;
                end
                if (o_rsp.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d actual %0d",
                           want.removed_value, o_rsp.removed_value);
                    mismatch_count++;
                end
                if (o_rsp.length !== want.length) begin
                    $error("length: expected %0d actual %0d", want.length, o_rsp.length);
                    mismatch_count++;
                end
            end
        end
    end

    // no accept on either channel for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ole_pkg.sv
hw/rtl/ole_datapath.sv
hw/rtl/ole_ctrl.sv
hw/rtl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
